/* hdl/axis_angle_rotation_matrix_macros.svh */
// Assertion macros for the axis-angle rotation matrix block.
// Used by the checker; no other dependencies.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// property checked out of reset
`define AAR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked while reset is held
`define AAR_ASSERT_IN_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) !rstn |-> (prop)) else $error(msg);

`endif

/* hdl/aar_pkg.sv */
// Types, Q.30 constants and helper functions for the rotation matrix block.
// No dependencies.
package aar_pkg;

  typedef logic signed [33:0] q30_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zero;
  } axv_t;

  localparam q30_t ONE_Q30     = 34'sd1073741824;
  localparam q30_t PI_Q30      = 34'sd3373259426;
  localparam q30_t TWO_PI_Q30  = 34'sd6746518852;
  localparam q30_t HALF_PI_Q30 = 34'sd1686629713;
  localparam q30_t CORDIC_K    = 34'sd652032874;

  localparam int CORDIC_STEPS = 30;
  localparam int PIPE_STAGES  = 71;

  function automatic q30_t atan_q30(input int i);
    q30_t v;
    case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: v = 34'sd1 <<< (30 - i);
    endcase
    return v;
  endfunction

  // round-to-nearest Q.30 product
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = a * b;
    p = p + (68'sd1 <<< 29);
    return q30_t'(p >>> 30);
  endfunction

endpackage

/* hdl/axis_angle_rotation_matrix.sv */
// Axis-angle to 3x3 rotation matrix (Rodrigues), fully pipelined.
// Depends on aar_pkg.
//
// Usage:
//   A request is taken on every rising edge with start_i high; busy_o is
//   always low, so one request per cycle is accepted.
//   angle_i is radians with FRAC_BITS fraction bits; axis_*_i is any scale.
//   The result appears on m00_o..m22_o and axis_zero_o, marked by done_o
//   for exactly one cycle, once the request has passed the pipeline.
//   Throughput is one result per cycle. Latency is set by the 31-step
//   square root and the three 31-step dividers that normalize the axis;
//   the 30-stage CORDIC runs beside them and is delayed to match.
//   A zero axis gives the identity matrix with axis_zero_o high.
//   Reset clears every valid bit: requests in flight are dropped and no
//   done_o is raised until a new request has passed the pipeline.
//   The receiver cannot stall; results are never held back.
module axis_angle_rotation_matrix import aar_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [17:0] angle_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               done_o,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o,
  output logic               axis_zero_o
);

  localparam int SH = 30 - FRAC_BITS;
  localparam int AW = 18 + SH;
  localparam int NK = (AW > 34) ? AW - 33 : 1;
  localparam int MW = 34 + NK;
  localparam int AD = 32 - NK;
  localparam logic signed [34:0] RND = (35'sd1 <<< SH) >>> 1;
  localparam logic signed [34:0] LIM = 35'sd1 <<< FRAC_BITS;
  localparam logic [34:0] ONE_OUT = 35'd1 << FRAC_BITS;

  assign busy_o = 1'b0;

  logic [PIPE_STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_STAGES-2:0], start_i & ~busy_o};
    end
  end

  assign done_o = vld_q[PIPE_STAGES-1];

  // input register
  logic signed [17:0] ang0_q;
  logic signed [15:0] ax0_q, ay0_q, az0_q;

  always_ff @(posedge clk_i) begin
    ang0_q <= angle_i;
    ax0_q  <= axis_x_i;
    ay0_q  <= axis_y_i;
    az0_q  <= axis_z_i;
  end

  // ---------------- angle path ----------------
  logic signed [AW-1:0] ang_sh;
  logic signed [MW-1:0] ang_w;
  logic [MW-1:0]        am_q [0:NK];
  logic                 an_q [0:NK];

  assign ang_sh = AW'(ang0_q) <<< SH;
  assign ang_w  = MW'(ang_sh);

  always_ff @(posedge clk_i) begin
    am_q[0] <= ang_w[MW-1] ? MW'(-ang_w) : MW'(ang_w);
    an_q[0] <= ang_w[MW-1];
  end

  for (genvar k = 1; k <= NK; k++) begin : g_mod
    localparam logic [MW-1:0] TW = MW'(TWO_PI_Q30) << (NK - k);
    always_ff @(posedge clk_i) begin
      am_q[k] <= (am_q[k-1] >= TW) ? am_q[k-1] - TW : am_q[k-1];
      an_q[k] <= an_q[k-1];
    end
  end

  q30_t wr_r;
  q30_t wr_q;

  assign wr_r = an_q[NK] ? -q30_t'(am_q[NK]) : q30_t'(am_q[NK]);

  always_ff @(posedge clk_i) begin
    if (wr_r > PI_Q30) begin
      wr_q <= wr_r - TWO_PI_Q30;
    end else if (wr_r < -PI_Q30) begin
      wr_q <= wr_r + TWO_PI_Q30;
    end else begin
      wr_q <= wr_r;
    end
  end

  q30_t cx_q [0:CORDIC_STEPS];
  q30_t cy_q [0:CORDIC_STEPS];
  q30_t cz_q [0:CORDIC_STEPS];
  logic cn_q [0:CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    cx_q[0] <= CORDIC_K;
    cy_q[0] <= '0;
    if (wr_q > HALF_PI_Q30) begin
      cz_q[0] <= wr_q - PI_Q30;
      cn_q[0] <= 1'b1;
    end else if (wr_q < -HALF_PI_Q30) begin
      cz_q[0] <= wr_q + PI_Q30;
      cn_q[0] <= 1'b1;
    end else begin
      cz_q[0] <= wr_q;
      cn_q[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam q30_t AT = atan_q30(i);
    q30_t dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      cn_q[i+1] <= cn_q[i];
      if (!cz_q[i][33]) begin
        cx_q[i+1] <= cx_q[i] - dx;
        cy_q[i+1] <= cy_q[i] + dy;
        cz_q[i+1] <= cz_q[i] - AT;
      end else begin
        cx_q[i+1] <= cx_q[i] + dx;
        cy_q[i+1] <= cy_q[i] - dy;
        cz_q[i+1] <= cz_q[i] + AT;
      end
    end
  end

  q30_t sd_q [0:AD];
  q30_t cd_q [0:AD];

  always_ff @(posedge clk_i) begin
    sd_q[0] <= cn_q[CORDIC_STEPS] ? -cy_q[CORDIC_STEPS] : cy_q[CORDIC_STEPS];
    cd_q[0] <= cn_q[CORDIC_STEPS] ? -cx_q[CORDIC_STEPS] : cx_q[CORDIC_STEPS];
  end

  for (genvar d = 1; d <= AD; d++) begin : g_dly
    always_ff @(posedge clk_i) begin
      sd_q[d] <= sd_q[d-1];
      cd_q[d] <= cd_q[d-1];
    end
  end

  // ---------------- axis path ----------------
  logic signed [31:0] sqx, sqy, sqz;
  logic [30:0]        sqx_q, sqy_q, sqz_q;
  axv_t               ax1_q;

  assign sqx = 32'(ax0_q) * 32'(ax0_q);
  assign sqy = 32'(ay0_q) * 32'(ay0_q);
  assign sqz = 32'(az0_q) * 32'(az0_q);

  always_ff @(posedge clk_i) begin
    sqx_q   <= sqx[30:0];
    sqy_q   <= sqy[30:0];
    sqz_q   <= sqz[30:0];
    ax1_q.x <= ax0_q;
    ax1_q.y <= ay0_q;
    ax1_q.z <= az0_q;
    ax1_q.zero <= 1'b0;
  end

  // integer square root of n2 * 2^30, two radicand bits per stage
  logic [31:0] sr_rem_q  [0:31];
  logic [30:0] sr_root_q [0:31];
  logic [61:0] sr_n_q    [0:31];
  axv_t        sr_ax_q   [0:31];
  logic [31:0] n2;

  assign n2 = 32'(sqx_q) + 32'(sqy_q) + 32'(sqz_q);

  always_ff @(posedge clk_i) begin
    sr_rem_q[0]  <= '0;
    sr_root_q[0] <= '0;
    sr_n_q[0]    <= {n2[31:0], 30'd0};
    sr_ax_q[0]   <= '{x: ax1_q.x, y: ax1_q.y, z: ax1_q.z, zero: (n2 == 32'd0)};
  end

  for (genvar j = 1; j <= 31; j++) begin : g_sqrt
    logic [33:0] rem2, trial;
    logic        ge;
    assign rem2  = {sr_rem_q[j-1], sr_n_q[j-1][61:60]};
    assign trial = {1'b0, sr_root_q[j-1], 2'b01};
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk_i) begin
      sr_rem_q[j]  <= ge ? 32'(rem2 - trial) : 32'(rem2);
      sr_root_q[j] <= {sr_root_q[j-1][29:0], ge};
      sr_n_q[j]    <= sr_n_q[j-1] << 2;
      sr_ax_q[j]   <= sr_ax_q[j-1];
    end
  end

  // three restoring dividers: (|v| * 2^45 + r/2) / r
  logic [30:0] dv_rem_q  [0:2][0:31];
  logic [30:0] dv_bits_q [0:2][0:31];
  logic [30:0] dv_quo_q  [0:2][0:31];
  logic [30:0] dv_r_q    [0:31];
  logic [2:0]  dv_sg_q   [0:31];
  logic        dv_z_q    [0:31];
  logic signed [15:0] axc [0:2];

  assign axc[0] = sr_ax_q[31].x;
  assign axc[1] = sr_ax_q[31].y;
  assign axc[2] = sr_ax_q[31].z;

  for (genvar c = 0; c < 3; c++) begin : g_div
    logic [15:0] mag;
    logic [60:0] dvd;
    assign mag = axc[c][15] ? 16'(-axc[c]) : 16'(axc[c]);
    assign dvd = {mag, 45'd0} + 61'(sr_root_q[31] >> 1);
    always_ff @(posedge clk_i) begin
      dv_rem_q[c][0]  <= {1'b0, dvd[60:31]};
      dv_bits_q[c][0] <= dvd[30:0];
      dv_quo_q[c][0]  <= '0;
    end
    for (genvar k = 1; k <= 31; k++) begin : g_step
      logic [31:0] rem2;
      logic        ge;
      assign rem2 = {dv_rem_q[c][k-1], dv_bits_q[c][k-1][30]};
      assign ge   = rem2 >= {1'b0, dv_r_q[k-1]};
      always_ff @(posedge clk_i) begin
        dv_rem_q[c][k]  <= ge ? 31'(rem2 - {1'b0, dv_r_q[k-1]}) : 31'(rem2);
        dv_bits_q[c][k] <= dv_bits_q[c][k-1] << 1;
        dv_quo_q[c][k]  <= {dv_quo_q[c][k-1][29:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_r_q[0]  <= sr_root_q[31];
    dv_sg_q[0] <= {axc[2][15], axc[1][15], axc[0][15]};
    dv_z_q[0]  <= sr_ax_q[31].zero;
  end

  for (genvar k = 1; k <= 31; k++) begin : g_dvc
    always_ff @(posedge clk_i) begin
      dv_r_q[k]  <= dv_r_q[k-1];
      dv_sg_q[k] <= dv_sg_q[k-1];
      dv_z_q[k]  <= dv_z_q[k-1];
    end
  end

  // unit vector
  q30_t u_q [0:2];
  logic uz_q;

  for (genvar c = 0; c < 3; c++) begin : g_unit
    q30_t qv;
    assign qv = q30_t'({3'd0, dv_quo_q[c][31]});
    always_ff @(posedge clk_i) begin
      u_q[c] <= dv_sg_q[31][c] ? -qv : qv;
    end
  end

  always_ff @(posedge clk_i) begin
    uz_q <= dv_z_q[31];
  end

  // ---------------- matrix ----------------
  q30_t t_w;
  q30_t tu1_q [0:2];
  q30_t su1_q [0:2];
  q30_t u1_q  [0:2];
  q30_t c1_q;
  logic z1_q;

  assign t_w = ONE_Q30 - cd_q[AD];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      tu1_q[c] <= qmul(t_w, u_q[c]);
      su1_q[c] <= qmul(sd_q[AD], u_q[c]);
      u1_q[c]  <= u_q[c];
    end
    c1_q <= cd_q[AD];
    z1_q <= uz_q;
  end

  q30_t p00_q, p01_q, p02_q, p11_q, p12_q, p22_q;
  q30_t su2_q [0:2];
  q30_t c2_q;
  logic z2_q;

  always_ff @(posedge clk_i) begin
    p00_q <= qmul(tu1_q[0], u1_q[0]);
    p01_q <= qmul(tu1_q[0], u1_q[1]);
    p02_q <= qmul(tu1_q[0], u1_q[2]);
    p11_q <= qmul(tu1_q[1], u1_q[1]);
    p12_q <= qmul(tu1_q[1], u1_q[2]);
    p22_q <= qmul(tu1_q[2], u1_q[2]);
    su2_q <= su1_q;
    c2_q  <= c1_q;
    z2_q  <= z1_q;
  end

  q30_t m3_q [0:8];
  logic z3_q;

  always_ff @(posedge clk_i) begin
    m3_q[0] <= p00_q + c2_q;
    m3_q[1] <= p01_q - su2_q[2];
    m3_q[2] <= p02_q + su2_q[1];
    m3_q[3] <= p01_q + su2_q[2];
    m3_q[4] <= p11_q + c2_q;
    m3_q[5] <= p12_q - su2_q[0];
    m3_q[6] <= p02_q - su2_q[1];
    m3_q[7] <= p12_q + su2_q[0];
    m3_q[8] <= p22_q + c2_q;
    z3_q    <= z2_q;
  end

  logic [15:0] mo_q [0:8];
  logic        zo_q;

  for (genvar k = 0; k < 9; k++) begin : g_out
    logic signed [34:0] rv;
    logic signed [34:0] sv;
    assign rv = (35'(m3_q[k]) + RND) >>> SH;
    assign sv = (rv > LIM) ? LIM : ((rv < -LIM) ? -LIM : rv);
    always_ff @(posedge clk_i) begin
      if (z3_q) begin
        mo_q[k] <= (k % 4 == 0) ? ONE_OUT[15:0] : 16'd0;
      end else begin
        mo_q[k] <= sv[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    zo_q <= z3_q;
  end

  assign m00_o       = mo_q[0];
  assign m01_o       = mo_q[1];
  assign m02_o       = mo_q[2];
  assign m10_o       = mo_q[3];
  assign m11_o       = mo_q[4];
  assign m12_o       = mo_q[5];
  assign m20_o       = mo_q[6];
  assign m21_o       = mo_q[7];
  assign m22_o       = mo_q[8];
  assign axis_zero_o = zo_q;

endmodule

/* hdl/aar_checker.sv */
// Port-level checker for the rotation matrix block, bound to the top level.
// Depends on aar_pkg and axis_angle_rotation_matrix_macros.svh.
`include "axis_angle_rotation_matrix_macros.svh"

module aar_checker import aar_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [17:0] angle_i,
  input logic signed [15:0] axis_x_i,
  input logic signed [15:0] axis_y_i,
  input logic signed [15:0] axis_z_i,
  input logic               done_o,
  input logic signed [15:0] m00_o,
  input logic signed [15:0] m01_o,
  input logic signed [15:0] m02_o,
  input logic signed [15:0] m10_o,
  input logic signed [15:0] m11_o,
  input logic signed [15:0] m12_o,
  input logic signed [15:0] m20_o,
  input logic signed [15:0] m21_o,
  input logic signed [15:0] m22_o,
  input logic               axis_zero_o
);

  localparam logic [31:0] ONE_W = 32'd1 << FRAC_BITS;
  localparam logic [15:0] ID = ONE_W[15:0];

  `AAR_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o, "busy raised")
  `AAR_ASSERT_IN_RST(a_quiet_in_reset, clk_i, rst_ni, !done_o, "done during reset")
  `AAR_ASSERT(a_done_has_request, clk_i, rst_ni, done_o |-> $past(start_i, PIPE_STAGES), "result without request")
  `AAR_ASSERT(a_zero_flag, clk_i, rst_ni, done_o |-> (axis_zero_o == $past(axis_x_i == 16'sd0 && axis_y_i == 16'sd0 && axis_z_i == 16'sd0, PIPE_STAGES)), "zero flag mismatch")
  `AAR_ASSERT(a_identity, clk_i, rst_ni, (done_o && axis_zero_o) |-> (m00_o == ID && m11_o == ID && m22_o == ID && m01_o == 16'sd0 && m12_o == 16'sd0 && m20_o == 16'sd0), "zero axis not identity")

endmodule

bind axis_angle_rotation_matrix aar_checker #(.FRAC_BITS(FRAC_BITS)) u_aar_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the axis-angle rotation matrix block.
// It predicts every matrix in Q.30 fixed point and compares each done_o strobe.
// Depends on aar_pkg and axis_angle_rotation_matrix.
module tb_top import aar_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC     = 14;
  localparam int  DRAIN    = 100;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [8:0][15:0] m;
    logic             zero;
  } matrix_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [17:0] angle_i = '0;
  logic signed [15:0] axis_x_i = '0;
  logic signed [15:0] axis_y_i = '0;
  logic signed [15:0] axis_z_i = '0;
  logic               done_o;
  logic signed [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;
  logic               axis_zero_o;

  matrix_t matrix_q[$];
  int      n_sent, n_checked, n_zero, n_mismatch;
  longint  n_cycles;

  always #2 clk_i = ~clk_i;

  axis_angle_rotation_matrix #(.FRAC_BITS(FRAC)) DUT (.*);

  function automatic longint qprod(longint a, longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint unit_part(longint v, longint r);
    longint unsigned mag, q;
    mag = longint'(v < 0 ? -v : v) << 45;
    q = (mag + longint'(r) / 2) / longint'(r);
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] to_q14(longint e);
    longint v, lim;
    lim = longint'(1) <<< FRAC;
    v = (e + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic matrix_t rotation_matrix(logic signed [17:0] ang,
      logic signed [15:0] vx, logic signed [15:0] vy, logic signed [15:0] vz);
    matrix_t res;
    longint ax, ay, az, n2, r, x, y, z, s, c, t, tx, ty, tz, a, zz, dx, dy, at;
    longint e[9];
    logic neg;
    ax = vx; ay = vy; az = vz;
    n2 = ax * ax + ay * ay + az * az;
    res = '0;
    if (n2 == 0) begin
      res.m[0] = 16'(1 << FRAC);
      res.m[4] = 16'(1 << FRAC);
      res.m[8] = 16'(1 << FRAC);
      res.zero = 1'b1;
      return res;
    end
    r = int_sqrt(longint'(n2) << 30);
    x = unit_part(ax, r);
    y = unit_part(ay, r);
    z = unit_part(az, r);
    a = longint'(ang) * (longint'(1) <<< (30 - FRAC));
    a = a % longint'(TWO_PI_Q30);
    if (a > longint'(PI_Q30)) a -= longint'(TWO_PI_Q30);
    if (a < -longint'(PI_Q30)) a += longint'(TWO_PI_Q30);
    neg = 1'b0;
    if (a > longint'(HALF_PI_Q30)) begin
      a -= longint'(PI_Q30);
      neg = 1'b1;
    end else if (a < -longint'(HALF_PI_Q30)) begin
      a += longint'(PI_Q30);
      neg = 1'b1;
    end
    c = longint'(CORDIC_K);
    s = 0;
    zz = a;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      at = longint'(atan_q30(i));
      dx = s >>> i;
      dy = c >>> i;
      if (zz >= 0) begin
        c -= dx; s += dy; zz -= at;
      end else begin
        c += dx; s -= dy; zz += at;
      end
    end
    if (neg) begin
      s = -s;
      c = -c;
    end
    t = longint'(ONE_Q30) - c;
    tx = qprod(t, x);
    ty = qprod(t, y);
    tz = qprod(t, z);
    e[0] = qprod(tx, x) + c;
    e[1] = qprod(tx, y) - qprod(s, z);
    e[2] = qprod(tx, z) + qprod(s, y);
    e[3] = qprod(tx, y) + qprod(s, z);
    e[4] = qprod(ty, y) + c;
    e[5] = qprod(ty, z) - qprod(s, x);
    e[6] = qprod(tx, z) - qprod(s, y);
    e[7] = qprod(ty, z) + qprod(s, x);
    e[8] = qprod(tz, z) + c;
    for (int k = 0; k < 9; k++) res.m[k] = to_q14(e[k]);
    return res;
  endfunction

  // caller is at a rising edge; start_i stays high if the next request follows
  task automatic send_request(logic signed [17:0] ang, logic signed [15:0] vx,
      logic signed [15:0] vy, logic signed [15:0] vz);
    start_i  <= 1'b1;
    angle_i  <= ang;
    axis_x_i <= vx;
    axis_y_i <= vy;
    axis_z_i <= vz;
    do @(posedge clk_i); while (busy_o);
    matrix_q.push_back(rotation_matrix(ang, vx, vy, vz));
    n_sent++;
  endtask

  task automatic idle_gap(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic test_axis_extremes();
    logic signed [17:0] angs[8] = '{18'sh1ffff, -18'sd131072, 18'sd0, 18'sd51472,
                                    -18'sd51472, 18'sd25736, -18'sd25735, 18'sd1};
    for (int i = 0; i < 8; i++) send_request(angs[i], 16'sd1, 16'sd0, 16'sd0);
    send_request(18'sd12000, 16'sd0, 16'sh7fff, 16'sd0);
    send_request(-18'sd30000, 16'sd0, 16'sd0, -16'sd32768);
    send_request(18'sd70000, -16'sd32768, -16'sd32768, -16'sd32768);
    send_request(18'sd51472, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_request(-18'sd100000, 16'sd1, -16'sd1, 16'sd1);
    idle_gap(3);
  endtask

  task automatic test_zero_axis();
    send_request(18'sh1ffff, 16'sd0, 16'sd0, 16'sd0);
    send_request(-18'sd131072, 16'sd0, 16'sd0, 16'sd0);
    send_request(18'sd0, 16'sd0, 16'sd0, 16'sd0);
    idle_gap(2);
  endtask

  task automatic test_random(int n_items);
    int left, burst;
    logic signed [15:0] v[3];
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && left > 0; b++, left--) begin
        for (int k = 0; k < 3; k++) v[k] = 16'($urandom);
        case ($urandom_range(0, 9))
          0: v = '{16'sd0, 16'sd0, 16'sd0};
          1: v[$urandom_range(0, 2)] = 16'sd0;
          2: for (int k = 0; k < 3; k++) v[k] = 16'($signed($urandom_range(0, 6)) - 3);
          default: ;
        endcase
        send_request(18'($urandom), v[0], v[1], v[2]);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);
  endtask

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", n_cycles, matrix_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni && done_o) begin
      got.m = {m22_o, m21_o, m20_o, m12_o, m11_o, m10_o, m02_o, m01_o, m00_o};
      got.zero = axis_zero_o;
      if (matrix_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result at cycle %0d", n_cycles);
      end else begin
        want = matrix_q.pop_front();
        n_checked++;
        if (want.zero) n_zero++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            for (int k = 0; k < 9; k++)
              if (got.m[k] !== want.m[k])
                $display("m%0d%0d: expected %0d got %0d", k / 3, k % 3,
                         $signed(want.m[k]), $signed(got.m[k]));
            if (got.zero !== want.zero)
              $display("axis_zero: expected %b got %b", want.zero, got.zero);
          end
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_axis_extremes();
    test_zero_axis();
    test_random(1150);
    while (matrix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("%0d requests sent, %0d matrices checked (%0d zero-axis), %0d mismatches",
             n_sent, n_checked, n_zero, n_mismatch);
    if (n_mismatch == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* sim.f */
+incdir+hdl
hdl/aar_pkg.sv
hdl/axis_angle_rotation_matrix.sv
hdl/aar_checker.sv
tb/sv/tb_top.sv
